// ===== rtl/ksc_pkg.sv =====
// ----------------------------------------------------------------------------
// ksc_pkg: shared types and constants for the keyword substitution cipher
// Command codes, field widths and the item and result records that pass
// between the top level and the key store.
// ----------------------------------------------------------------------------
package ksc_pkg;

   // Field widths
   localparam int LETTER_W = 5;
   localparam int CMD_W    = 2;
   // Letter compares against lengths that can reach the alphabet size (32)
   localparam int CMP_W    = LETTER_W + 1;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   // Default alphabet size
   localparam int ALPHABET_SIZE_DEFAULT = 26;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DECODE = 2'd3;

   // One command as taken from the request channel
   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [LETTER_W-1:0] letter;
   } item_type;

   // One result as sent on the response channel
   typedef struct packed {
      logic                status;
      logic [LETTER_W-1:0] result_letter;
   } result_type;

endpackage

// ===== rtl/keyword_substitution_cipher_top.sv =====
// A request passes the stage register and key store to the response register.
// Throughput: one command per cycle unless rsp_tready stalls; key store reads
// and updates share a cycle, so consecutive commands see each other's effect.
// Reset (synchronous, active high) empties the key and both stream stages.
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_top: keyword substitution cipher, stream ports
// Request stage register, key store lookup, response register.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_top #(
   parameter int ALPHABET_SIZE = ksc_pkg::ALPHABET_SIZE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [4:0] letter, [7:5] zero
   input  logic [ksc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [ksc_pkg::CMD_W-1:0]      req_tuser,
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [4:0] result_letter, [5] status, [7:6] zero
   output logic [ksc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                stage_valid_ff;
   ksc_pkg::item_type   stage_item_ff;
   logic                rsp_valid_ff;
   ksc_pkg::result_type rsp_result_ff;

   ksc_pkg::result_type result;
   logic                advance;
   logic                req_transfer;

   // Move the staged command on when the response register is free
   assign advance      = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !stage_valid_ff || advance;
   assign req_transfer = req_tvalid && req_tready;

   // Hold the accepted command in the stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         stage_item_ff.command <= req_tuser;
         stage_item_ff.letter  <= req_tdata[ksc_pkg::LETTER_W-1:0];
      end
   end

   ksc_key_store #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_key_store (
      .clock  (clock),
      .reset  (reset),
      .item   (stage_item_ff),
      .apply  (advance),
      .result (result)
   );

   // Load the response register; drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ksc_pkg::RSP_DATA_W'(rsp_result_ff);

endmodule

// ===== rtl/ksc_key_store.sv =====
// ----------------------------------------------------------------------------
// ksc_key_store: key state and single-pass encode/decode lookup
// Holds the key letters, their positions, the used-letter mask and, for each
// letter, the count of unused letters below it. The result for the presented
// command is combinational; the state update lands when apply is high.
// ----------------------------------------------------------------------------
module ksc_key_store #(
   parameter int ALPHABET_SIZE = ksc_pkg::ALPHABET_SIZE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ksc_pkg::item_type    item,
   input  logic                 apply,
   output ksc_pkg::result_type  result
);

   localparam int IDX_W    = $clog2(ALPHABET_SIZE);
   localparam int LEN_W    = $clog2(ALPHABET_SIZE + 1);
   localparam int LETTER_W = ksc_pkg::LETTER_W;
   localparam int CMP_W    = ksc_pkg::CMP_W;

   // Key storage: no reset, entries are read only once written
   logic [LETTER_W-1:0]      key_letters_ff  [ALPHABET_SIZE];
   logic [LETTER_W-1:0]      key_position_ff [ALPHABET_SIZE];
   // Control state
   logic [LETTER_W-1:0]      below_ff        [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] used_ff;
   logic [LEN_W-1:0]         key_length_ff;

   logic [CMP_W-1:0]    letter_ext;
   logic [CMP_W-1:0]    length_ext;
   logic [IDX_W-1:0]    idx;
   logic                in_range;
   logic                letter_used;
   logic                key_full;
   logic                key_hit;
   logic                append_ok;
   logic [LETTER_W-1:0] target;
   logic [LETTER_W-1:0] free_letter;
   logic [LETTER_W-1:0] encoded;
   logic [LETTER_W-1:0] decoded;

   // Decode the letter against the current key
   assign letter_ext  = CMP_W'(item.letter);
   assign length_ext  = CMP_W'(key_length_ff);
   assign idx         = item.letter[IDX_W-1:0];
   assign in_range    = letter_ext < CMP_W'(ALPHABET_SIZE);
   assign letter_used = in_range && used_ff[idx];
   assign key_full    = length_ext >= CMP_W'(ALPHABET_SIZE);
   assign key_hit     = letter_ext < length_ext;
   assign append_ok   = in_range && !letter_used && !key_full;
   assign target      = LETTER_W'(letter_ext - length_ext);

   // Pick the unused letter whose rank among unused letters matches target
   always_comb begin
      free_letter = '0;
      for (int c = 0; c < ALPHABET_SIZE; c++) begin
         if (!used_ff[c] && (below_ff[c] == target)) begin
            free_letter = free_letter | LETTER_W'(c);
         end
      end
   end

   assign encoded = key_hit ? key_letters_ff[idx] : free_letter;
   assign decoded = letter_used ? key_position_ff[idx]
                                : LETTER_W'(length_ext + CMP_W'(below_ff[idx]));

   // Form the result for the presented command
   always_comb begin
      result = '0;
      unique case (item.command)
         ksc_pkg::CMD_CLEAR: begin
            result = '0;
         end
         ksc_pkg::CMD_APPEND: begin
            result.status = !append_ok;
         end
         ksc_pkg::CMD_ENCODE: begin
            result.result_letter = in_range ? encoded : '0;
         end
         ksc_pkg::CMD_DECODE: begin
            result.result_letter = in_range ? decoded : '0;
         end
      endcase
   end

   // Update length, used mask and unused-below counts
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
         used_ff       <= '0;
         for (int c = 0; c < ALPHABET_SIZE; c++) begin
            below_ff[c] <= LETTER_W'(c);
         end
      end else if (apply) begin
         if (item.command == ksc_pkg::CMD_CLEAR) begin
            key_length_ff <= '0;
            used_ff       <= '0;
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
               below_ff[c] <= LETTER_W'(c);
            end
         end else if (item.command == ksc_pkg::CMD_APPEND && append_ok) begin
            key_length_ff <= key_length_ff + 1'b1;
            used_ff[idx]  <= 1'b1;
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
               if (LETTER_W'(c) > item.letter) begin
                  below_ff[c] <= below_ff[c] - 1'b1;
               end
            end
         end
      end
   end

   // Record the appended letter and its key position
   always_ff @(posedge clock) begin
      if (apply && item.command == ksc_pkg::CMD_APPEND && append_ok) begin
         key_letters_ff[key_length_ff[IDX_W-1:0]] <= item.letter;
         key_position_ff[idx]                     <= LETTER_W'(key_length_ff);
      end
   end

endmodule
